// File: rtl/sbsi_pkg.sv
// Shared types and constants for the segment/box slab intersection block.
// Used by the top level and by the pipelined slab divider.
`default_nettype none
package sbsi_pkg;

   localparam int AXES  = 3;
   localparam int NUM_W = 33;
   localparam int REM_W = 34;

   typedef enum logic [1:0] {
      CSR_SIZE_X    = 2'd0,
      CSR_SIZE_Y    = 2'd1,
      CSR_SIZE_Z    = 2'd2,
      CSR_TOLERANCE = 2'd3
   } csr_index_type;

   // Per-request data that travels alongside the divider pipeline.
   typedef struct packed {
      logic [AXES-1:0][31:0] start;
      logic [AXES-1:0][31:0] disp;
      logic [AXES-1:0]       degen;
      logic [AXES-1:0]       par;
      logic [AXES-1:0]       outside;
      logic [AXES-1:0]       neg0;
      logic [AXES-1:0]       neg1;
   } meta_type;

endpackage
`default_nettype wire

// File: rtl/segment_box_slab_intersect_top.sv
// Top level of the segment/box slab intersection pipeline.
// Depends on sbsi_pkg and instantiates six sbsi_div slab dividers.
`default_nettype none
// A request is accepted at a rising clock edge where start is high and busy is
// low. Busy is always low, so a new request may be issued in every cycle.
// Each request gives exactly one result: rsp_valid is high for one cycle with
// rsp_hit and the hit point on rsp_point_x/y/z, which are zero on a miss.
// The receiver cannot stall; every stage advances on every clock.
// Throughput is one request per cycle. The latency is set by the slab
// dividers, which resolve one quotient bit per stage over PARAM_FRAC_BITS + 3
// stages, plus eight stages for the slab setup, the overlap tests, the
// multiply and the final rounding and saturation.
// Box sizes and tolerance are written through csr_we, csr_index and
// csr_wdata; a write takes effect at once and should be made only while no
// request is in flight.
// Synchronous reset restores the register defaults (unit box, tolerance of
// one LSB) and drops any request that is in flight.
module segment_box_slab_intersect_top #(
   parameter int COORD_FRAC_BITS = 16,
   parameter int PARAM_FRAC_BITS = 30
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic signed [31:0]          req_start_x,
   input  wire logic signed [31:0]          req_start_y,
   input  wire logic signed [31:0]          req_start_z,
   input  wire logic signed [31:0]          req_disp_x,
   input  wire logic signed [31:0]          req_disp_y,
   input  wire logic signed [31:0]          req_disp_z,
   input  wire logic                        csr_we,
   input  wire sbsi_pkg::csr_index_type     csr_index,
   input  wire logic [30:0]                 csr_wdata,
   output logic                             rsp_valid,
   output logic                             rsp_hit,
   output logic signed [31:0]               rsp_point_x,
   output logic signed [31:0]               rsp_point_y,
   output logic signed [31:0]               rsp_point_z
);
   import sbsi_pkg::*;

   localparam int P     = PARAM_FRAC_BITS;
   localparam int QW    = P + 3;
   localparam int TW    = P + 4;
   localparam int PW    = P + 33;
   localparam int LAT   = QW + 1;
   localparam int LAST  = LAT + 5;
   localparam int SH_L  = (PARAM_FRAC_BITS >= COORD_FRAC_BITS) ?
                          PARAM_FRAC_BITS - COORD_FRAC_BITS : 0;
   localparam int SH_R  = (PARAM_FRAC_BITS >= COORD_FRAC_BITS) ?
                          0 : COORD_FRAC_BITS - PARAM_FRAC_BITS;
   localparam int CW    = (P + 6 > 18 + SH_L) ? P + 6 : 18 + SH_L;

   localparam logic [QW-1:0]        T_SAT_Q = {3'b100, {P{1'b0}}};
   localparam logic signed [TW-1:0] T_ONE_T = {3'b000, 1'b1, {P{1'b0}}};
   localparam logic signed [CW-1:0] T_ONE_C = CW'(T_ONE_T);

   // Configuration registers.
   logic [30:0] size_ff [AXES];
   logic [15:0] tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff[0] <= 31'd65536;
         size_ff[1] <= 31'd65536;
         size_ff[2] <= 31'd65536;
         tol_ff     <= 16'd1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SIZE_X:    size_ff[0] <= csr_wdata;
            CSR_SIZE_Y:    size_ff[1] <= csr_wdata;
            CSR_SIZE_Z:    size_ff[2] <= csr_wdata;
            CSR_TOLERANCE: tol_ff     <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Tolerance in parameter units, wide enough for any shift.
   logic signed [CW-1:0] tol_t;
   assign tol_t = $signed((CW'(tol_ff) << SH_L) >> SH_R);

   assign busy = 1'b0;

   // Valid bits and side data ride a shift line beside the dividers.
   logic     v_ff    [0:LAST];
   meta_type meta_ff [0:LAST];

   // Stage 1: slab numerators, denominators and per-axis flags.
   logic [31:0]        st_in   [AXES];
   logic [31:0]        dp_in   [AXES];
   logic signed [34:0] num0_in [AXES];
   logic signed [34:0] num1_in [AXES];
   logic [32:0]        den1_in [AXES];
   meta_type           meta_in;

   always_comb begin
      logic [31:0]        smag;
      logic [31:0]        dmag;
      logic signed [34:0] s2;
      logic signed [34:0] sz;
      logic [32:0]        limit;
      st_in[0] = req_start_x;
      st_in[1] = req_start_y;
      st_in[2] = req_start_z;
      dp_in[0] = req_disp_x;
      dp_in[1] = req_disp_y;
      dp_in[2] = req_disp_z;
      for (int a = 0; a < AXES; a++) begin
         smag  = st_in[a][31] ? 32'(-st_in[a]) : st_in[a];
         dmag  = dp_in[a][31] ? 32'(-dp_in[a]) : dp_in[a];
         s2    = {st_in[a][31], st_in[a][31], st_in[a], 1'b0};
         sz    = {4'b0000, size_ff[a]};
         limit = {2'b00, size_ff[a]} + {16'd0, tol_ff, 1'b0};
         num0_in[a] = -sz - s2;
         num1_in[a] = sz - s2;
         den1_in[a] = {dmag, 1'b0};
         meta_in.start[a]   = st_in[a];
         meta_in.disp[a]    = dp_in[a];
         meta_in.degen[a]   = {2'b00, size_ff[a]} <= {16'd0, tol_ff, 1'b0};
         meta_in.par[a]     = dmag <= {16'd0, tol_ff};
         meta_in.outside[a] = {smag, 1'b0} > limit;
         meta_in.neg0[a]    = num0_in[a][34] ^ dp_in[a][31];
         meta_in.neg1[a]    = num1_in[a][34] ^ dp_in[a][31];
      end
   end

   logic signed [34:0] num0_ff [AXES];
   logic signed [34:0] num1_ff [AXES];
   logic [32:0]        den1_ff [AXES];
   logic [32:0]        n0_ff   [AXES];
   logic [32:0]        n1_ff   [AXES];
   logic [32:0]        den2_ff [AXES];

   always_ff @(posedge clock) begin
      for (int a = 0; a < AXES; a++) begin
         num0_ff[a] <= num0_in[a];
         num1_ff[a] <= num1_in[a];
         den1_ff[a] <= den1_in[a];
         // Stage 2: magnitudes for the unsigned dividers.
         n0_ff[a]   <= num0_ff[a][34] ? 33'(-num0_ff[a]) : num0_ff[a][32:0];
         n1_ff[a]   <= num1_ff[a][34] ? 33'(-num1_ff[a]) : num1_ff[a][32:0];
         den2_ff[a] <= den1_ff[a];
      end
      meta_ff[0] <= meta_in;
      for (int i = 0; i < LAST; i++) begin
         meta_ff[i+1] <= meta_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LAST; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else begin
         v_ff[0] <= start & ~busy;
         for (int i = 0; i < LAST; i++) begin
            v_ff[i+1] <= v_ff[i];
         end
      end
   end

   // Slab dividers, two per axis.
   logic [QW-1:0] q0 [AXES];
   logic [QW-1:0] q1 [AXES];
   logic          ovf0 [AXES];
   logic          ovf1 [AXES];

   for (genvar a = 0; a < AXES; a++) begin : g_axis
      sbsi_div #(.FRAC_BITS(P)) u_div0 (
         .clock(clock), .num(n0_ff[a]), .den(den2_ff[a]), .quot(q0[a]), .ovf(ovf0[a])
      );
      sbsi_div #(.FRAC_BITS(P)) u_div1 (
         .clock(clock), .num(n1_ff[a]), .den(den2_ff[a]), .quot(q1[a]), .ovf(ovf1[a])
      );
   end

   // Stage C: saturate, sign and order the slab parameters. A parallel axis
   // places no limit on the parameter range.
   logic signed [TW-1:0] enter_c_in [AXES];
   logic signed [TW-1:0] exit_c_in  [AXES];
   logic signed [TW-1:0] enter_c_ff [AXES];
   logic signed [TW-1:0] exit_c_ff  [AXES];

   always_comb begin
      logic [QW-1:0]        qs0;
      logic [QW-1:0]        qs1;
      logic signed [TW-1:0] t0;
      logic signed [TW-1:0] t1;
      for (int a = 0; a < AXES; a++) begin
         qs0 = (ovf0[a] || q0[a] > T_SAT_Q) ? T_SAT_Q : q0[a];
         qs1 = (ovf1[a] || q1[a] > T_SAT_Q) ? T_SAT_Q : q1[a];
         t0  = meta_ff[LAT+1].neg0[a] ? -$signed(TW'(qs0)) : $signed(TW'(qs0));
         t1  = meta_ff[LAT+1].neg1[a] ? -$signed(TW'(qs1)) : $signed(TW'(qs1));
         if (meta_ff[LAT+1].par[a]) begin
            enter_c_in[a] = '0;
            exit_c_in[a]  = T_ONE_T;
         end else if (t0 > t1) begin
            enter_c_in[a] = t1;
            exit_c_in[a]  = t0;
         end else begin
            enter_c_in[a] = t0;
            exit_c_in[a]  = t1;
         end
      end
   end

   // Stage D: overall entry and exit parameters.
   logic signed [TW-1:0] enter_d_in;
   logic signed [TW-1:0] exit_d_in;
   logic signed [TW-1:0] enter_d_ff;
   logic signed [TW-1:0] exit_d_ff;
   logic                 miss_d_ff;
   logic                 inside_d_ff;

   always_comb begin
      enter_d_in = '0;
      exit_d_in  = T_ONE_T;
      for (int a = 0; a < AXES; a++) begin
         if (enter_c_ff[a] > enter_d_in) begin
            enter_d_in = enter_c_ff[a];
         end
         if (exit_c_ff[a] < exit_d_in) begin
            exit_d_in = exit_c_ff[a];
         end
      end
   end

   // Stage E: overlap and range tests, then clamp the hit parameter.
   logic signed [CW-1:0] diff_e;
   logic signed [CW-1:0] thit_e;
   logic                 hit_e_in;
   logic [P:0]           t_e_in;
   logic                 hit_e_ff;
   logic [P:0]           t_e_ff;

   always_comb begin
      diff_e   = CW'(enter_d_ff) - CW'(exit_d_ff);
      thit_e   = inside_d_ff ? CW'(exit_d_ff) : CW'(enter_d_ff);
      hit_e_in = !miss_d_ff && !(diff_e > tol_t) &&
                 !(thit_e < -tol_t) && !(thit_e > T_ONE_C + tol_t);
      if (thit_e < 0) begin
         t_e_in = '0;
      end else if (thit_e > T_ONE_C) begin
         t_e_in = T_ONE_C[P:0];
      end else begin
         t_e_in = thit_e[P:0];
      end
   end

   // Stage F: displacement magnitude times the hit parameter.
   logic [PW-1:0] prod_f_ff [AXES];
   logic          hit_f_ff;

   always_ff @(posedge clock) begin
      logic [31:0] dmag;
      for (int a = 0; a < AXES; a++) begin
         enter_c_ff[a] <= enter_c_in[a];
         exit_c_ff[a]  <= exit_c_in[a];
      end
      enter_d_ff  <= enter_d_in;
      exit_d_ff   <= exit_d_in;
      miss_d_ff   <= |(meta_ff[LAT+2].degen | (meta_ff[LAT+2].par & meta_ff[LAT+2].outside));
      inside_d_ff <= ~|meta_ff[LAT+2].outside;
      hit_e_ff    <= hit_e_in;
      t_e_ff      <= t_e_in;
      for (int a = 0; a < AXES; a++) begin
         dmag = meta_ff[LAT+4].disp[a][31] ? 32'(-meta_ff[LAT+4].disp[a])
                                           : meta_ff[LAT+4].disp[a];
         prod_f_ff[a] <= PW'(dmag) * PW'(t_e_ff);
      end
      hit_f_ff <= hit_e_ff;
   end

   // Stage G: round to nearest, add the start point and saturate.
   logic [31:0] point_g_in [AXES];

   always_comb begin
      logic [PW-1:0]      rnd;
      logic [32:0]        delta;
      logic signed [33:0] s34;
      logic signed [33:0] sum;
      for (int a = 0; a < AXES; a++) begin
         rnd   = prod_f_ff[a] + (PW'(1) << (P - 1));
         delta = rnd[P+32:P];
         s34   = {{2{meta_ff[LAST].start[a][31]}}, meta_ff[LAST].start[a]};
         if (meta_ff[LAST].disp[a][31]) begin
            sum = s34 - $signed({1'b0, delta});
         end else begin
            sum = s34 + $signed({1'b0, delta});
         end
         if (!hit_f_ff) begin
            point_g_in[a] = '0;
         end else if (sum > 34'sd2147483647) begin
            point_g_in[a] = 32'h7FFF_FFFF;
         end else if (sum < -34'sd2147483648) begin
            point_g_in[a] = 32'h8000_0000;
         end else begin
            point_g_in[a] = sum[31:0];
         end
      end
   end

   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= v_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit     <= hit_f_ff;
      rsp_point_x <= point_g_in[0];
      rsp_point_y <= point_g_in[1];
      rsp_point_z <= point_g_in[2];
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// File: rtl/sbsi_div.sv
// Pipelined restoring divider for the slab quotients, one quotient bit per stage.
// Depends on sbsi_pkg for the numerator and remainder widths.
`default_nettype none
module sbsi_div #(
   parameter int FRAC_BITS = 30
) (
   input  wire logic                          clock,
   input  wire logic [sbsi_pkg::NUM_W-1:0]    num,
   input  wire logic [sbsi_pkg::NUM_W-1:0]    den,
   output logic      [FRAC_BITS+2:0]          quot,
   output logic                               ovf
);
   import sbsi_pkg::*;

   localparam int QBITS = FRAC_BITS + 3;

   logic [NUM_W-1:0] num_ff  [0:QBITS];
   logic [NUM_W-1:0] den_ff  [0:QBITS];
   logic [REM_W-1:0] rem_ff  [0:QBITS];
   logic [QBITS-1:0] quot_ff [0:QBITS];
   logic             ovf_ff  [0:QBITS];

   logic [REM_W-1:0] rem_in  [0:QBITS-1];
   logic [QBITS-1:0] qbit_in;

   // Each stage shifts in the next dividend bit and tries one subtraction.
   always_comb begin
      int bit_pos;
      int num_pos;
      logic [REM_W-1:0] trial;
      logic             dbit;
      for (int k = 0; k < QBITS; k++) begin
         bit_pos = QBITS - 1 - k;
         num_pos = bit_pos - FRAC_BITS;
         dbit    = 1'b0;
         if (num_pos >= 0) begin
            dbit = num_ff[k][num_pos[1:0]];
         end
         trial      = {rem_ff[k][REM_W-2:0], dbit};
         qbit_in[k] = trial >= REM_W'(den_ff[k]);
         rem_in[k]  = qbit_in[k] ? trial - REM_W'(den_ff[k]) : trial;
      end
   end

   always_ff @(posedge clock) begin
      num_ff[0]  <= num;
      den_ff[0]  <= den;
      rem_ff[0]  <= REM_W'(num >> 3);
      quot_ff[0] <= '0;
      ovf_ff[0]  <= {3'b000, num} >= {den, 3'b000};
      for (int k = 0; k < QBITS; k++) begin
         num_ff[k+1]  <= num_ff[k];
         den_ff[k+1]  <= den_ff[k];
         rem_ff[k+1]  <= rem_in[k];
         ovf_ff[k+1]  <= ovf_ff[k];
         quot_ff[k+1] <= quot_ff[k] | (QBITS'(qbit_in[k]) << (QBITS - 1 - k));
      end
   end

   assign quot = quot_ff[QBITS];
   assign ovf  = ovf_ff[QBITS];

endmodule
`default_nettype wire
